// ===== hw/rtl/fbik_pkg.sv =====
package fbik_pkg;

  // datapath widths
  localparam int RW = 42;            // raw products and sums, units of 2^-32 m^2
  localparam int AW = 34;            // scaled a, b, c, units of 2^-27 m^2
  localparam int MW = 33;            // magnitude of a scaled value
  localparam int NW = 36;            // numerator and denominator of the half angle
  localparam int CW = 40;            // rotation vector components
  localparam int ZW = 25;            // angle accumulator, units of 2^-16 degree
  localparam int TW = 16;            // output angle, units of 1/128 degree

  localparam int SCALE_SHIFT  = 5;
  localparam int SQRT_STEPS   = 32;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 20;

  localparam logic signed [18:0] OFFSET_X  = 19'sd2621;
  localparam logic signed [18:0] OFFSET_Y  = 19'sd786;
  localparam logic signed [16:0] HALF_TURN = 17'sd23040;
  localparam logic signed [16:0] FULL_TURN = 17'sd46080;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNREACH  = 2'd1,
    ST_ZERO_DEN = 2'd2
  } status_t;

  // square root chain payload
  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic signed [AW-1:0]   bs;
    logic signed [NW-1:0]   den;
    logic [63:0]            n;
    logic [63:0]            res;
  } sqrt_t;

  // normalize and rotation chain payload
  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } rot_t;

  // solved angle of one joint
  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic signed [TW-1:0]   angle;
  } ang_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    case (i)
      0:       atan_step = 25'sd2949120;
      1:       atan_step = 25'sd1740967;
      2:       atan_step = 25'sd919879;
      3:       atan_step = 25'sd466945;
      4:       atan_step = 25'sd234379;
      5:       atan_step = 25'sd117304;
      6:       atan_step = 25'sd58666;
      7:       atan_step = 25'sd29335;
      8:       atan_step = 25'sd14668;
      9:       atan_step = 25'sd7334;
      10:      atan_step = 25'sd3667;
      11:      atan_step = 25'sd1833;
      12:      atan_step = 25'sd917;
      13:      atan_step = 25'sd458;
      14:      atan_step = 25'sd229;
      15:      atan_step = 25'sd115;
      16:      atan_step = 25'sd57;
      17:      atan_step = 25'sd29;
      18:      atan_step = 25'sd14;
      19:      atan_step = 25'sd7;
      default: atan_step = '0;
    endcase
  endfunction

  // shift of the magnitude, truncating toward zero
  function automatic logic signed [CW-1:0] shift_trunc(input logic signed [CW-1:0] v,
                                                      input int i);
    logic signed [CW-1:0] neg;
    neg = -v;
    shift_trunc = v[CW-1] ? -(neg >>> i) : (v >>> i);
  endfunction

  // drop SCALE_SHIFT bits of the magnitude, rounding half away from zero
  function automatic logic signed [AW-1:0] scale_down(input logic signed [RW-1:0] v);
    logic [RW-1:0] m;
    logic signed [AW-1:0] ms;
    m  = v[RW-1] ? $unsigned(-v) : $unsigned(v);
    m  = (m + (RW'(1) << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
    ms = $signed(m[AW-1:0]);
    scale_down = v[RW-1] ? -ms : ms;
  endfunction

endpackage

// ===== hw/rtl/fbik_sqrt_cell.sv =====
module fbik_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fbik_pkg::sqrt_t d_i,
  output fbik_pkg::sqrt_t q_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STAGE);

  fbik_pkg::sqrt_t q_r, q_nxt;
  logic [63:0]     trial;

  // one result bit per cell
  always_comb begin
    trial = d_i.res + BIT;
    q_nxt = d_i;
    if (d_i.n >= trial) begin
      q_nxt.n   = d_i.n - trial;
      q_nxt.res = (d_i.res >> 1) + BIT;
    end else begin
      q_nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== hw/rtl/fbik_norm_cell.sv =====
module fbik_norm_cell #(
  parameter int SHIFT = 1,
  parameter int LIMIT = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  fbik_pkg::rot_t d_i,
  output fbik_pkg::rot_t q_o
);

  localparam int CW = fbik_pkg::CW;

  fbik_pkg::rot_t q_r, q_nxt;
  logic [CW-1:0]  mx, my;

  // shift both components left by SHIFT while both stay below 2^LIMIT
  always_comb begin
    mx    = d_i.x[CW-1] ? $unsigned(-d_i.x) : $unsigned(d_i.x);
    my    = d_i.y[CW-1] ? $unsigned(-d_i.y) : $unsigned(d_i.y);
    q_nxt = d_i;
    if ((mx | my) < (CW'(1) << LIMIT)) begin
      q_nxt.x = d_i.x <<< SHIFT;
      q_nxt.y = d_i.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== hw/rtl/fbik_cordic_cell.sv =====
module fbik_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  fbik_pkg::rot_t d_i,
  output fbik_pkg::rot_t q_o
);

  localparam int CW = fbik_pkg::CW;

  fbik_pkg::rot_t       q_r, q_nxt;
  logic signed [CW-1:0] xs, ys;

  // vectoring step: rotate toward y = 0
  always_comb begin
    xs    = fbik_pkg::shift_trunc(d_i.x, STEP);
    ys    = fbik_pkg::shift_trunc(d_i.y, STEP);
    q_nxt = d_i;
    if (!d_i.y[CW-1]) begin
      q_nxt.x = d_i.x + ys;
      q_nxt.y = d_i.y - xs;
      q_nxt.z = d_i.z + fbik_pkg::atan_step(STEP);
    end else begin
      q_nxt.x = d_i.x - ys;
      q_nxt.y = d_i.y + xs;
      q_nxt.z = d_i.z - fbik_pkg::atan_step(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// ===== hw/rtl/fbik_solver.sv =====
module fbik_solver #(
  parameter bit MINUS = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [19:0]  p,
  input  logic signed [18:0]  y,
  input  logic [16:0]         l1,
  input  logic [16:0]         l2,
  output fbik_pkg::ang_t      ang_o
);

  localparam int RW = fbik_pkg::RW;
  localparam int AW = fbik_pkg::AW;
  localparam int MW = fbik_pkg::MW;
  localparam int NW = fbik_pkg::NW;
  localparam int CW = fbik_pkg::CW;
  localparam int ZW = fbik_pkg::ZW;
  localparam int TW = fbik_pkg::TW;
  localparam int SQ = fbik_pkg::SQRT_STEPS;
  localparam int NS = fbik_pkg::NORM_STEPS;
  localparam int CS = fbik_pkg::CORDIC_STEPS;

  // stage 1: products
  logic signed [17:0]   l1s;
  logic signed [37:0]   pa, ya;
  logic signed [39:0]   pp;
  logic signed [37:0]   yy;
  logic [33:0]          l1q, l2q;
  logic                 v1_r;
  logic signed [RW-1:0] a1_r, b1_r, pp1_r, yy1_r, l1q1_r, l2q1_r;

  assign l1s = $signed({1'b0, l1});
  assign pa  = p * l1s;
  assign ya  = y * l1s;
  assign pp  = p * p;
  assign yy  = y * y;
  assign l1q = l1 * l1;
  assign l2q = l2 * l2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= RW'(pa) <<< 1;
      b1_r   <= RW'(ya) <<< 1;
      pp1_r  <= RW'(pp);
      yy1_r  <= RW'(yy);
      l1q1_r <= $signed(RW'(l1q));
      l2q1_r <= $signed(RW'(l2q));
    end
  end

  // stage 2: c and scaled a, b
  logic                 v2_r;
  logic signed [RW-1:0] c2_r;
  logic signed [AW-1:0] as2_r, bs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r  <= pp1_r + yy1_r + l1q1_r - l2q1_r;
      as2_r <= fbik_pkg::scale_down(a1_r);
      bs2_r <= fbik_pkg::scale_down(b1_r);
    end
  end

  // stage 3: scaled c
  logic                 v3_r;
  logic signed [AW-1:0] as3_r, bs3_r, cs3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as3_r <= as2_r;
      bs3_r <= bs2_r;
      cs3_r <= fbik_pkg::scale_down(c2_r);
    end
  end

  // stage 4: squares and denominator
  logic [MW-1:0]        ma, mb, mc;
  logic [2*MW-1:0]      qa, qb, qc;
  logic                 v4_r;
  logic [63:0]          qa4_r, qb4_r, qc4_r;
  logic signed [AW-1:0] bs4_r;
  logic signed [NW-1:0] den4_r;

  assign ma = as3_r[AW-1] ? MW'($unsigned(-as3_r)) : MW'($unsigned(as3_r));
  assign mb = bs3_r[AW-1] ? MW'($unsigned(-bs3_r)) : MW'($unsigned(bs3_r));
  assign mc = cs3_r[AW-1] ? MW'($unsigned(-cs3_r)) : MW'($unsigned(cs3_r));
  assign qa = ma * ma;
  assign qb = mb * mb;
  assign qc = mc * mc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa4_r  <= qa[63:0];
      qb4_r  <= qb[63:0];
      qc4_r  <= qc[63:0];
      bs4_r  <= bs3_r;
      den4_r <= NW'(cs3_r) + NW'(as3_r);
    end
  end

  // stage 5: a^2 + b^2
  logic                 v5_r;
  logic [63:0]          sum5_r, csq5_r;
  logic signed [AW-1:0] bs5_r;
  logic signed [NW-1:0] den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum5_r <= qa4_r + qb4_r;
      csq5_r <= qc4_r;
      bs5_r  <= bs4_r;
      den5_r <= den4_r;
    end
  end

  // stage 6: discriminant and status into the root chain
  fbik_pkg::sqrt_t sq [SQ+1];
  fbik_pkg::sqrt_t sq0_nxt;

  always_comb begin
    sq0_nxt.valid = v5_r;
    sq0_nxt.bs    = bs5_r;
    sq0_nxt.den   = den5_r;
    sq0_nxt.n     = sum5_r - csq5_r;
    sq0_nxt.res   = '0;
    if (sum5_r < csq5_r) begin
      sq0_nxt.status = fbik_pkg::ST_UNREACH;
    end else if (den5_r == '0) begin
      sq0_nxt.status = fbik_pkg::ST_ZERO_DEN;
    end else begin
      sq0_nxt.status = fbik_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0] <= sq0_nxt;
    end
  end

  // square root, one bit per cell
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    fbik_sqrt_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (sq[g]),
      .q_o   (sq[g+1])
    );
  end

  // stage 7: numerator, sign fix of the denominator
  fbik_pkg::rot_t       rt [NS+CS+1];
  fbik_pkg::rot_t       rt0_nxt;
  logic signed [NW-1:0] root, num;

  always_comb begin
    root = $signed(NW'(sq[SQ].res[31:0]));
    num  = MINUS ? (NW'(sq[SQ].bs) - root) : (NW'(sq[SQ].bs) + root);
    rt0_nxt.valid  = sq[SQ].valid;
    rt0_nxt.status = sq[SQ].status;
    rt0_nxt.z      = '0;
    if (sq[SQ].den[NW-1]) begin
      rt0_nxt.x = -CW'(sq[SQ].den);
      rt0_nxt.y = -CW'(num);
    end else begin
      rt0_nxt.x = CW'(sq[SQ].den);
      rt0_nxt.y = CW'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt[0].valid <= 1'b0;
    end else if (en) begin
      rt[0] <= rt0_nxt;
    end
  end

  // normalize so one component reaches 2^32
  for (genvar g = 0; g < NS; g++) begin : g_norm
    localparam int SH = (g < NS - 1) ? (16 >> g) : 1;
    localparam int LM = (g < NS - 1) ? (32 - (16 >> g)) : 32;
    fbik_norm_cell #(.SHIFT(SH), .LIMIT(LM)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (rt[g]),
      .q_o   (rt[g+1])
    );
  end

  // atan by vectoring rotations
  for (genvar g = 0; g < CS; g++) begin : g_cordic
    fbik_cordic_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (rt[NS+g]),
      .q_o   (rt[NS+g+1])
    );
  end

  // output: double, round to 1/128 degree, clamp
  fbik_pkg::rot_t last;
  fbik_pkg::ang_t ang_r, ang_nxt;
  logic [ZW-1:0]  mz, t;

  assign last = rt[NS+CS];

  always_comb begin
    mz = last.z[ZW-1] ? $unsigned(-last.z) : $unsigned(last.z);
    t  = (mz + ZW'(128)) >> 8;
    if (t > ZW'(fbik_pkg::HALF_TURN)) begin
      t = ZW'(fbik_pkg::HALF_TURN);
    end
    ang_nxt.valid  = last.valid;
    ang_nxt.status = last.status;
    if (last.status != fbik_pkg::ST_OK) begin
      ang_nxt.angle = '0;
    end else if (last.z[ZW-1]) begin
      ang_nxt.angle = -$signed(t[TW-1:0]);
    end else begin
      ang_nxt.angle = $signed(t[TW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r.valid <= 1'b0;
    end else if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign ang_o = ang_r;

endmodule

// ===== hw/rtl/five_bar_inverse_kinematics.sv =====
// Inverse kinematics of a planar five-bar linkage: target (x, y) in, two
// drive joint angles out, each with a status (0 ok, 1 unreachable, 2 zero
// denominator; the angle is 0 when the status is not ok).
// Input channel in_*: tdata carries target_x and target_y. Output channel
// out_*: tdata carries joint_angle_a and joint_angle_b, tuser the statuses.
// Configuration channel cfg_*: index 0..4 selects link a, b, c, d length and
// base spacing; other indexes are dropped. Write only while the block is idle.
// Throughput is one point per cycle while the receiver does not stall: each
// item moves one cell per cycle down a fixed chain (offsets, products,
// scaling, squares, discriminant, 32 square-root cells, numerator, 6
// normalize cells, 20 rotation cells, rounding, angle fold, output register).
// When the receiver stalls, the whole chain holds, and in_tready follows
// out_tready whenever a result is waiting; empty slots do not hold the chain.
// Reset clears the link registers to 0 and empties the chain.
module five_bar_inverse_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  // target_x [17:0], target_y [35:18], zero fill [39:36]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // joint_angle_a [15:0], joint_angle_b [31:16]
  output logic [31:0] out_tdata,
  // status_a [1:0], status_b [3:2]
  output logic [3:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam logic [2:0] REG_LINK_A = 3'd0;
  localparam logic [2:0] REG_LINK_B = 3'd1;
  localparam logic [2:0] REG_LINK_C = 3'd2;
  localparam logic [2:0] REG_LINK_D = 3'd3;
  localparam logic [2:0] REG_BASE   = 3'd4;

  logic [16:0] link_a_r, link_b_r, link_c_r, link_d_r, base_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_a_r <= '0;
      link_b_r <= '0;
      link_c_r <= '0;
      link_d_r <= '0;
      base_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINK_A: link_a_r <= cfg_data;
        REG_LINK_B: link_b_r <= cfg_data;
        REG_LINK_C: link_c_r <= cfg_data;
        REG_LINK_D: link_d_r <= cfg_data;
        REG_BASE:   base_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // chain advance
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 0: offsets
  logic                v0_r;
  logic signed [18:0]  x0_r, y0_r;
  logic signed [19:0]  xe0_r;
  logic signed [18:0]  x_in, y_in;

  assign x_in = 19'($signed(in_tdata[17:0])) + fbik_pkg::OFFSET_X;
  assign y_in = 19'($signed(in_tdata[35:18])) + fbik_pkg::OFFSET_Y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r  <= x_in;
      y0_r  <= y_in;
      xe0_r <= 20'(x_in) - $signed({3'b000, base_r});
    end
  end

  // one solver per joint
  fbik_pkg::ang_t ang_a, ang_b;

  fbik_solver #(.MINUS(1'b0)) u_solver_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v0_r),
    .p        (20'(x0_r)),
    .y        (y0_r),
    .l1       (link_a_r),
    .l2       (link_b_r),
    .ang_o    (ang_a)
  );

  fbik_solver #(.MINUS(1'b1)) u_solver_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v0_r),
    .p        (xe0_r),
    .y        (y0_r),
    .l1       (link_d_r),
    .l2       (link_c_r),
    .ang_o    (ang_b)
  );

  // first joint: 180 minus the angle, folded into (-180, 180]
  logic signed [16:0] fold;

  always_comb begin
    fold = fbik_pkg::HALF_TURN - 17'(ang_a.angle);
    if (fold > fbik_pkg::HALF_TURN) begin
      fold = fold - fbik_pkg::FULL_TURN;
    end
    if (ang_a.status != fbik_pkg::ST_OK) begin
      fold = '0;
    end
  end

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [3:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ang_a.valid && ang_b.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {ang_b.angle, fold[15:0]};
      out_user_r <= {ang_b.status, ang_a.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
